>>> design/htpr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// htpr_pkg
// Shared types and constants of the header/tail packet reassembler.
// ============================================================================
package htpr_pkg;

  // Byte banks of the packet store, one per byte lane of a 64-bit word.
  localparam int LANES       = 8;
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = LANES * BYTE_W;
  localparam int MAX_RESULTS = 16;

  // Input stream layout: frame_length then eight data words.
  localparam int IN_LEN_W    = 7;
  localparam int IN_WORDS    = 8;
  localparam int IN_BYTES    = IN_WORDS * LANES;
  localparam int IN_TDATA_W  = 520;
  localparam int OUT_TDATA_W = 72;
  localparam int NB_W        = 4;

  // Configuration port.
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE      = 2'd2;

  localparam logic [7:0] PAYLOAD_LENGTH_RST = 8'd8;
  localparam logic [7:0] HEADER_BYTE_RST    = 8'd165;
  localparam logic [7:0] TAIL_BYTE_RST      = 8'd90;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ
  } state_t;

  // One chunk of eight frame bytes on its way into the byte banks.
  typedef struct packed {
    logic              en;
    logic [7:0]        base;
    logic [6:0]        rem;
    logic [WORD_W-1:0] chunk;
  } wr_lane_t;

endpackage

>>> design/header_tail_packet_reassembler.sv
`timescale 1ns / 1ps
// ============================================================================
// header_tail_packet_reassembler
// Collects received frames into a header/payload/tail packet and streams the
// payload out as 64-bit words.
// ============================================================================
// A frame request is taken while the block is idle. Its bytes then go into
// eight byte-wide store banks, eight bytes per cycle, while the input is
// held off. When a packet completes with a matching tail, each payload word
// is one bank read followed by a load of the output register, up to sixteen
// words per packet; a new read waits for that load and for a free output
// register. The store needs no clearing pass after reset: only bytes written
// for the current packet are read back. The next frame is taken while the
// last payload word still waits in the output register.
// ============================================================================
module header_tail_packet_reassembler import htpr_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 128,
  parameter int FRAME_MAX_BYTES   = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Frame input.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // From bit 0: frame_length[6:0], data_word_0 .. data_word_7, one zero pad bit.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Payload output.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // From bit 0: payload_word[63:0], valid_bytes[3:0], four zero pad bits.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast
);

  localparam int STORE_BYTES = MAX_PAYLOAD_BYTES + 2;
  localparam int ROWS        = (STORE_BYTES + LANES - 1) / LANES;
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FRAME_WORDS = (FRAME_MAX_BYTES + LANES - 1) / LANES;

  // Configuration registers.
  logic [7:0] payload_length;
  logic [7:0] header_byte;
  logic [7:0] tail_byte;

  state_t state, state_next;

  logic              collecting;
  logic [7:0]        fill_count;
  logic [7:0]        last_byte;
  logic [WORD_W-1:0] frame_buf [FRAME_WORDS];
  logic [7:0]        wr_base;
  logic [6:0]        wr_rem;
  logic              go_read;
  logic [7:0]        rd_plen;
  logic [3:0]        rd_word;
  logic              rd_pend;
  logic [NB_W-1:0]   rd_nb;
  logic              rd_last;

  logic [WORD_W-1:0] m_data;
  logic [NB_W-1:0]   m_nb;
  logic              m_valid;
  logic              m_last;

  // Frame decode.
  logic [7:0]        plen_eff;
  logic [8:0]        total;
  logic [6:0]        len_raw;
  logic [6:0]        len_c;
  logic [7:0]        in_bytes [IN_BYTES];
  logic [5:0]        last_idx;
  logic              head_ok;
  logic              take;
  logic [8:0]        sum;
  logic              overflow;
  logic              complete;
  logic [7:0]        new_tail;
  logic              tail_ok;
  logic              accept;

  // Read side.
  logic [7:0]        rd_rem;
  logic              rd_end;
  logic              rd_final;
  logic              rd_issue;
  logic [NB_W-1:0]   issue_nb;

  wr_lane_t          wr;
  logic [BYTE_W-1:0] lane_data [LANES];
  logic [WORD_W-1:0] merged;

  // --------------------------------------------------------------------------
  // Configuration.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_length <= PAYLOAD_LENGTH_RST;
      header_byte    <= HEADER_BYTE_RST;
      tail_byte      <= TAIL_BYTE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PAYLOAD_LENGTH: payload_length <= cfg_data;
        REG_HEADER_BYTE:    header_byte    <= cfg_data;
        REG_TAIL_BYTE:      tail_byte      <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Frame decode.
  // --------------------------------------------------------------------------
  always_comb begin
    if (payload_length == 8'd0) begin
      plen_eff = 8'd1;
    end else if ({1'b0, payload_length} > 9'(MAX_PAYLOAD_BYTES)) begin
      plen_eff = 8'(MAX_PAYLOAD_BYTES);
    end else begin
      plen_eff = payload_length;
    end
  end

  assign total   = {1'b0, plen_eff} + 9'd2;
  assign len_raw = s_axis_tdata[IN_LEN_W-1:0];
  assign len_c   = (len_raw > 7'(FRAME_MAX_BYTES)) ? 7'(FRAME_MAX_BYTES) : len_raw;

  always_comb begin
    for (int i = 0; i < IN_BYTES; i++) begin
      in_bytes[i] = s_axis_tdata[IN_LEN_W + 8*i +: 8];
    end
  end

  assign last_idx = 6'(len_c - 7'd1);
  assign head_ok  = (len_c != 7'd0) && (in_bytes[0] == header_byte);
  assign take     = collecting || head_ok;
  assign sum      = {1'b0, fill_count} + {2'b0, len_c};
  assign overflow = sum > total;
  assign complete = sum == total;
  // At completion the tail is the last byte written, possibly by an earlier frame.
  assign new_tail = (len_c != 7'd0) ? in_bytes[last_idx] : last_byte;
  assign tail_ok  = new_tail == tail_byte;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Read sequencing.
  // --------------------------------------------------------------------------
  assign rd_rem   = rd_plen - {1'b0, rd_word, 3'b000};
  assign rd_end   = rd_rem <= 8'd8;
  assign rd_final = rd_end || (rd_word == 4'(MAX_RESULTS - 1));
  assign issue_nb = rd_end ? rd_rem[NB_W-1:0] : NB_W'(LANES);

  // --------------------------------------------------------------------------
  // Control state machine.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && take && !overflow) begin
          if (len_c != 7'd0) begin
            state_next = ST_WRITE;
          end else if (complete && tail_ok) begin
            state_next = ST_READ;
          end
        end
      end
      ST_WRITE: begin
        if (wr_rem <= 7'd8) begin
          state_next = go_read ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        if (rd_issue && rd_final) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    rd_issue      = (state == ST_READ) && !rd_pend && (!m_valid || m_axis_tready);
    wr.en         = (state == ST_WRITE);
    wr.base       = wr_base;
    wr.rem        = wr_rem;
    wr.chunk      = frame_buf[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      collecting <= 1'b0;
      fill_count <= '0;
      rd_pend    <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (accept && take) begin
        // Overflow and completion both end the packet and reset the fill count.
        if (overflow || complete) begin
          collecting <= 1'b0;
          fill_count <= '0;
        end else begin
          collecting <= 1'b1;
          fill_count <= sum[7:0];
        end
      end

      rd_pend <= rd_issue;

      if (rd_pend) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept && take && !overflow) begin
      last_byte <= new_tail;
      wr_base   <= fill_count;
      wr_rem    <= len_c;
      go_read   <= complete && tail_ok;
      rd_plen   <= plen_eff;
      rd_word   <= '0;
      for (int w = 0; w < FRAME_WORDS; w++) begin
        frame_buf[w] <= s_axis_tdata[IN_LEN_W + WORD_W*w +: WORD_W];
      end
    end else if (state == ST_WRITE) begin
      wr_base <= wr_base + 8'd8;
      wr_rem  <= wr_rem - 7'd8;
      for (int w = 0; w < FRAME_WORDS - 1; w++) begin
        frame_buf[w] <= frame_buf[w+1];
      end
      frame_buf[FRAME_WORDS-1] <= '0;
    end

    if (rd_issue) begin
      rd_word <= rd_word + 4'd1;
      rd_nb   <= issue_nb;
      rd_last <= rd_end;
    end

    if (rd_pend) begin
      m_data <= merged;
      m_nb   <= rd_nb;
      m_last <= rd_last;
    end
  end

  // --------------------------------------------------------------------------
  // Byte banks and merge.
  // --------------------------------------------------------------------------
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    htpr_lane #(
      .BANK (b),
      .ROWS (ROWS),
      .ROW_W(ROW_W)
    ) u_lane (
      .clk    (clk),
      .wr     (wr),
      .rd_word(rd_word),
      .rd_data(lane_data[b])
    );
  end

  htpr_merge u_merge (
    .lane_data(lane_data),
    .nb       (rd_nb),
    .word     (merged)
  );

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'b0000, m_nb, m_data};
  assign m_axis_tlast  = m_last;

endmodule

>>> design/htpr_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// htpr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module htpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 17,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/htpr_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// htpr_lane
// One byte bank of the packet store: picks its byte of each incoming chunk,
// works out the row it lands in, and reads its byte of an outgoing word.
// ============================================================================
module htpr_lane import htpr_pkg::*; #(
  parameter int BANK  = 0,
  parameter int ROWS  = 17,
  parameter int ROW_W = 5
) (
  input  logic              clk,
  input  wr_lane_t          wr,
  input  logic [3:0]        rd_word,
  output logic [BYTE_W-1:0] rd_data
);

  logic [2:0]        k;
  logic              we;
  logic [8:0]        pos;
  logic [ROW_W-1:0]  waddr;
  logic [ROW_W-1:0]  raddr;
  logic [BYTE_W-1:0] wdata;
  logic [4:0]        rd_row;

  // Byte k of the chunk goes to position base + k, which falls in this bank.
  assign k     = 3'(BANK) - wr.base[2:0];
  assign we    = wr.en && ({4'b0, k} < wr.rem);
  assign pos   = {1'b0, wr.base} + {6'b0, k};
  assign waddr = pos[ROW_W+2:3];
  assign wdata = wr.chunk[{k, 3'b000} +: BYTE_W];

  // Word j covers positions 8j+1 to 8j+8, so only bank zero is one row ahead.
  assign rd_row = {1'b0, rd_word} + ((BANK == 0) ? 5'd1 : 5'd0);
  assign raddr  = ROW_W'(rd_row);

  htpr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(ROWS),
    .AW   (ROW_W)
  ) u_bank (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd_data)
  );

endmodule

>>> design/htpr_merge.sv
`timescale 1ns / 1ps
// ============================================================================
// htpr_merge
// Combines the bytes read from the eight banks into one payload word and
// zeroes the byte lanes past the end of the payload.
// ============================================================================
module htpr_merge import htpr_pkg::*; (
  input  logic [BYTE_W-1:0] lane_data [LANES],
  input  logic [NB_W-1:0]   nb,
  output logic [WORD_W-1:0] word
);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (NB_W'(k) < nb) begin
        word[k*BYTE_W +: BYTE_W] = lane_data[(k + 1) % LANES];
      end else begin
        word[k*BYTE_W +: BYTE_W] = '0;
      end
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the header/tail packet reassembler.
// ============================================================================
// Frames are queued by a stimulus process and offered on the input stream by a
// clocked driver. Every accepted frame goes through a packet predictor that
// keeps its own copy of the registers, the collection state and the packet
// store, and that queues the payload words the packet should produce. Every
// accepted payload word is compared with the oldest queued word. Directed
// frames cover the special cases. Randomized phases then run under several
// register settings, with a stretch where the sink holds off for a long time.
// ============================================================================
module tb_top;
  import htpr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STORE_SIZE       = 130;
  localparam int FRAME_BYTES      = 64;
  localparam int PAYLOAD_MAX      = 128;
  localparam int FRAMES_PER_PHASE = 12;
  localparam int NUM_PHASES       = 8;
  localparam int SETTLE_CYCLES    = 40;
  localparam int HOLD_CYCLES      = 300;
  localparam int QUIET_LIMIT      = 5000;

  typedef struct {
    logic [6:0]   len;
    logic [511:0] data;
  } frame_t;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } payload_t;

  typedef enum {PK_GOOD, PK_BAD_TAIL, PK_OVERFLOW} pkt_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // From bit 0: frame_length[6:0], data_word_0 .. data_word_7, one zero pad bit.
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // From bit 0: payload_word[63:0], valid_bytes[3:0], four zero pad bits.
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // Register copies, also used to build packets.
  logic [7:0] plen_reg = PAYLOAD_LENGTH_RST;
  logic [7:0] hdr_reg  = HEADER_BYTE_RST;
  logic [7:0] tail_reg = TAIL_BYTE_RST;

  // Predicted collection state.
  bit         collecting = 1'b0;
  int         fill_cnt = 0;
  logic [7:0] pkt_store [0:STORE_SIZE-1];

  frame_t   frame_q[$];
  payload_t payload_q[$];

  bit in_fire = 1'b0;
  bit steady = 1'b0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;

  header_tail_packet_reassembler i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_payload_len();
    int n;
    n = plen_reg;
    if (n == 0) n = 1;
    if (n > PAYLOAD_MAX) n = PAYLOAD_MAX;
    return n;
  endfunction

  function automatic logic [511:0] rand_bytes();
    logic [511:0] v;
    for (int i = 0; i < 16; i++) v[32*i +: 32] = $urandom;
    return v;
  endfunction

  function automatic void clear_packet();
    for (int i = 0; i < STORE_SIZE; i++) pkt_store[i] = 8'd0;
    collecting = 1'b0;
    fill_cnt = 0;
  endfunction

  // Appends one accepted frame and queues the payload words of a completed
  // packet whose tail matches.
  function automatic void reassemble_frame(input logic [6:0] flen, input logic [511:0] bytes);
    int       n;
    int       plen;
    int       total;
    int       off;
    int       nb;
    payload_t w;
    n = flen;
    if (n > FRAME_BYTES) n = FRAME_BYTES;
    plen = eff_payload_len();
    total = plen + 2;
    if (!collecting) begin
      if (n == 0 || bytes[7:0] != hdr_reg) return;
      collecting = 1'b1;
    end
    if (fill_cnt + n > total) begin
      clear_packet();
      return;
    end
    for (int i = 0; i < n; i++) pkt_store[fill_cnt + i] = bytes[8*i +: 8];
    fill_cnt += n;
    if (fill_cnt != total) return;
    if (pkt_store[plen + 1] == tail_reg) begin
      off = 0;
      while (off < plen) begin
        nb = (plen - off > 8) ? 8 : plen - off;
        w.word = '0;
        for (int k = 0; k < nb; k++) w.word[8*k +: 8] = pkt_store[1 + off + k];
        off += nb;
        w.nbytes = 4'(nb);
        w.last = (off >= plen);
        payload_q.push_back(w);
      end
    end
    clear_packet();
  endfunction

  task automatic report(input string what);
    if (mismatches < 50) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Sender: a request stays up until taken; new ones start at falling edges.
  always @(negedge clk) begin : drive_frames
    frame_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (frame_q.size() != 0 && (steady || $urandom_range(0, 99) >= 11)) begin
        nxt = frame_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, nxt.data, nxt.len};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random stalls, plus one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
    end
  end

  // Output words are checked before the frame of the same edge is predicted,
  // since a word can never belong to a frame taken at that very edge.
  always @(posedge clk) begin : watch
    payload_t want;
    bit       in_acc;
    bit       out_acc;
    in_acc = !rst && s_axis_tvalid && s_axis_tready;
    out_acc = !rst && m_axis_tvalid && m_axis_tready;
    if (out_acc) begin
      if (payload_q.size() == 0) begin
        report($sformatf("unexpected payload word %h", m_axis_tdata[63:0]));
      end else begin
        want = payload_q.pop_front();
        if (m_axis_tdata[63:0] !== want.word)
          report($sformatf("payload_word %h, want %h", m_axis_tdata[63:0], want.word));
        if (m_axis_tdata[67:64] !== want.nbytes)
          report($sformatf("valid_bytes %0d, want %0d", m_axis_tdata[67:64], want.nbytes));
        if (m_axis_tlast !== want.last)
          report($sformatf("last_word %b, want %b", m_axis_tlast, want.last));
      end
    end
    if (in_acc) reassemble_frame(s_axis_tdata[6:0], s_axis_tdata[518:7]);
    in_fire <= in_acc;
    if (rst || in_acc || out_acc) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PAYLOAD_LENGTH: plen_reg = val;
      REG_HEADER_BYTE:    hdr_reg = val;
      REG_TAIL_BYTE:      tail_reg = val;
      default: ;
    endcase
  endtask

  task automatic push_frame(input logic [6:0] len, input logic [511:0] data);
    frame_t f;
    f.len = len;
    f.data = data;
    frame_q.push_back(f);
    frames_sent++;
  endtask

  // Waits until all frames are taken and all words are out, then lets a frame
  // that causes no result finish inside the block. The check runs at rising
  // edges, where the sender's outputs have settled.
  task automatic drain();
    while (frame_q.size() != 0 || s_axis_tvalid || payload_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Builds header, random payload and tail under the current settings and
  // splits them into frames of at most chunk bytes; only the final frame of an overflowing packet may be longer.
  task automatic send_packet(input pkt_kind_t kind, input int chunk, input bit gap);
    logic [7:0]   pkt [0:STORE_SIZE-1];
    logic [511:0] data;
    int           total;
    int           off;
    int           n;
    int           cap;
    total = eff_payload_len() + 2;
    pkt[0] = hdr_reg;
    for (int i = 1; i < total - 1; i++) pkt[i] = 8'($urandom);
    pkt[total-1] = tail_reg;
    if (kind == PK_BAD_TAIL) pkt[total-1] = tail_reg ^ 8'($urandom_range(1, 255));
    off = 0;
    while (off < total) begin
      cap = total - off;
      if (cap > chunk) cap = chunk;
      if (kind == PK_OVERFLOW && cap > 63) cap = 63;
      n = $urandom_range(1, cap);
      data = rand_bytes();
      for (int i = 0; i < n; i++) data[8*i +: 8] = pkt[off + i];
      off += n;
      // The final frame of an overflowing packet runs past the expected total.
      if (kind == PK_OVERFLOW && off == total) n += $urandom_range(1, 64 - n);
      push_frame(7'(n), data);
      if (gap && off < total) begin
        push_frame(7'd0, rand_bytes());
        gap = 1'b0;
      end
    end
  endtask

  task automatic send_noise();
    logic [511:0] data;
    data = rand_bytes();
    if ($urandom_range(0, 9) < 3) data[7:0] = hdr_reg;
    push_frame(7'($urandom_range(0, 127)), data);
  endtask

  initial begin : stimulus
    logic [511:0] data;
    int           r;
    int           phase_end;
    clear_packet();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings.
    push_frame(7'd0, rand_bytes());
    data = rand_bytes();
    data[7:0] = hdr_reg ^ 8'h01;
    push_frame(7'd10, data);
    send_packet(PK_GOOD, 64, 1'b0);
    send_packet(PK_BAD_TAIL, 64, 1'b0);
    data = rand_bytes();
    data[7:0] = hdr_reg;
    push_frame(7'd127, data);
    send_packet(PK_OVERFLOW, 64, 1'b0);
    send_packet(PK_GOOD, 3, 1'b1);
    send_packet(PK_GOOD, 1, 1'b0);
    // A packet left open while the payload length shrinks is closed by an
    // empty frame.
    data = rand_bytes();
    data[7:0] = hdr_reg;
    data[47:40] = tail_reg;
    push_frame(7'd6, data);
    drain();
    write_reg(REG_PAYLOAD_LENGTH, 8'd4);
    push_frame(7'd0, rand_bytes());
    drain();
    write_reg(REG_UNUSED, 8'($urandom));
    write_reg(REG_PAYLOAD_LENGTH, PAYLOAD_LENGTH_RST);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      steady = (p == 0);
      write_reg(REG_UNUSED, 8'($urandom));
      case (p)
        0: begin
          write_reg(REG_PAYLOAD_LENGTH, 8'd8);
          write_reg(REG_HEADER_BYTE, 8'd165);
          write_reg(REG_TAIL_BYTE, 8'd90);
        end
        1: begin
          write_reg(REG_PAYLOAD_LENGTH, 8'd1);
          write_reg(REG_HEADER_BYTE, 8'd0);
          write_reg(REG_TAIL_BYTE, 8'd255);
        end
        2: begin
          write_reg(REG_PAYLOAD_LENGTH, 8'd128);
          write_reg(REG_HEADER_BYTE, 8'd255);
          write_reg(REG_TAIL_BYTE, 8'd0);
        end
        3: write_reg(REG_PAYLOAD_LENGTH, 8'd24);
        4: write_reg(REG_PAYLOAD_LENGTH, 8'd0);
        5: write_reg(REG_PAYLOAD_LENGTH, 8'd200);
        6: write_reg(REG_PAYLOAD_LENGTH, 8'd255);
        default: write_reg(REG_PAYLOAD_LENGTH, 8'($urandom_range(1, 128)));
      endcase
      if (p >= 3) begin
        write_reg(REG_HEADER_BYTE, 8'($urandom));
        write_reg(REG_TAIL_BYTE, 8'($urandom));
      end
      phase_end = frames_sent + FRAMES_PER_PHASE;
      while (frames_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 70)
          send_packet(PK_GOOD, ($urandom_range(0, 1) != 0) ? 64 : $urandom_range(1, 64),
                      $urandom_range(0, 9) == 0);
        else if (r < 80)
          send_packet(PK_BAD_TAIL, $urandom_range(1, 64), 1'b0);
        else if (r < 90)
          send_packet(PK_OVERFLOW, $urandom_range(1, 64), 1'b0);
        else
          send_noise();
      end
      // The sink starts a long hold-off as the frames of this phase are offered.
      if (p == 3) hold_go = 1'b1;
    end

    drain();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/htpr_pkg.sv
design/htpr_ram.sv
design/htpr_lane.sv
design/htpr_merge.sv
design/header_tail_packet_reassembler.sv
dv/tb_top.sv
